// ===== hdl/rpms_pkg.sv =====
// rpms_pkg: shared types, constants and helper functions for the radius point match search
// no dependencies; imported by every module of the block but rpms_check
package rpms_pkg;

    localparam int ANGLE_W     = 32;
    localparam int COS_W       = 30;
    localparam int RADIUS_W    = 31;
    localparam int COUNT_OUT_W = 9;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [COS_W-1:0]   Q_ONE       = 30'h2000_0000;
    localparam logic [ANGLE_W-1:0] PI_Q29      = 32'd1686629713;
    localparam logic [ANGLE_W-1:0] HALF_PI_Q29 = 32'd843314856;
    localparam logic [2:0]         HORNER_STEPS = 3'd5;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_COS,
        FR_PUSH
    } fr_state_t;

    typedef enum logic [2:0] {
        COS_IDLE,
        COS_SQUARE,
        COS_X2,
        COS_TMUL,
        COS_RECIP,
        COS_EST,
        COS_FIX,
        COS_DONE
    } cos_phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN
    } bk_state_t;

    typedef struct packed {
        op_t                op;
        logic [ANGLE_W-1:0] lon;
        logic [ANGLE_W-1:0] lat;
        logic [COS_W-1:0]   cosv;
    } q_entry_t;

    typedef struct packed {
        logic               start;
        logic [ANGLE_W-1:0] lat;
    } cos_req_t;

    typedef struct packed {
        logic             done;
        logic [COS_W-1:0] cosv;
    } cos_rsp_t;

    function automatic op_t classify(input logic [1:0] mode);
        op_t op;
        case (mode)
            MODE_CLEAR:  op = OP_CLEAR;
            MODE_APPEND: op = OP_APPEND;
            MODE_QUERY:  op = OP_QUERY;
            default:     op = OP_NONE;
        endcase
        return op;
    endfunction

    // taylor divisors of the cosine series, innermost first
    function automatic logic [7:0] horner_divisor(input logic [2:0] step);
        logic [7:0] k;
        case (step)
            3'd0:    k = 8'd132;
            3'd1:    k = 8'd90;
            3'd2:    k = 8'd56;
            3'd3:    k = 8'd30;
            3'd4:    k = 8'd12;
            default: k = 8'd1;
        endcase
        return k;
    endfunction

    // floor(2^32 / divisor), saturated to 2^32 - 1 for the default divisor of 1
    function automatic logic [31:0] horner_recip(input logic [2:0] step);
        logic [31:0] m;
        case (step)
            3'd0:    m = 32'd32537631;
            3'd1:    m = 32'd47721858;
            3'd2:    m = 32'd76695844;
            3'd3:    m = 32'd143165576;
            3'd4:    m = 32'd357913941;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/rpms_cos.sv =====
// rpms_cos: iterative |cos(lat)| unit on one shared 32x32 multiplier
// depends on rpms_pkg
module rpms_cos (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpms_pkg::cos_req_t req,
    output rpms_pkg::cos_rsp_t rsp
);
    import rpms_pkg::*;

    cos_phase_t        phase_reg, phase_next;
    logic [COS_W-1:0]  x_reg;
    logic [30:0]       x2_reg;
    logic [COS_W-1:0]  t_reg;
    logic [30:0]       n_reg;
    logic [COS_W-1:0]  q_reg;
    logic [2:0]        step_reg;
    logic [63:0]       prod_reg;
    logic [COS_W-1:0]  cos_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [31:0] lat_abs;
    logic [31:0] x_fold;
    logic [30:0] rem;
    logic [COS_W-1:0] q_fix;
    logic [COS_W-1:0] q_last;

    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign lat_abs = req.lat[31] ? (32'd0 - req.lat) : req.lat;
    assign rem     = n_reg - prod_reg[30:0];
    assign q_fix   = (rem >= {23'd0, horner_divisor(step_reg)}) ? (q_reg + 30'd1) : q_reg;
    assign q_last  = prod_reg[59:30];

    // fold the angle into [0, pi/2]
    always_comb begin
        if (lat_abs >= PI_Q29) begin
            x_fold = lat_abs - PI_Q29;
        end else if (lat_abs > HALF_PI_Q29) begin
            x_fold = PI_Q29 - lat_abs;
        end else begin
            x_fold = lat_abs;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            COS_IDLE: begin
                if (req.start) begin
                    phase_next = COS_SQUARE;
                end
            end
            COS_SQUARE: phase_next = COS_X2;
            COS_X2:     phase_next = COS_TMUL;
            COS_TMUL:   phase_next = COS_RECIP;
            COS_RECIP: begin
                if (step_reg == HORNER_STEPS) begin
                    phase_next = COS_DONE;
                end else begin
                    phase_next = COS_EST;
                end
            end
            COS_EST:  phase_next = COS_FIX;
            COS_FIX:  phase_next = COS_TMUL;
            COS_DONE: phase_next = COS_IDLE;
            default:  phase_next = COS_IDLE;
        endcase
    end

    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        rsp.done = 1'b0;
        rsp.cosv = cos_reg;
        case (phase_reg)
            COS_SQUARE: begin
                mul_a = {2'd0, x_reg};
                mul_b = {2'd0, x_reg};
            end
            COS_TMUL: begin
                mul_a = {1'b0, x2_reg};
                mul_b = {2'd0, t_reg};
            end
            COS_RECIP: begin
                mul_a = {1'b0, prod_reg[59:29]};
                mul_b = horner_recip(step_reg);
            end
            COS_EST: begin
                mul_a = {2'd0, prod_reg[61:32]};
                mul_b = {24'd0, horner_divisor(step_reg)};
            end
            COS_DONE: rsp.done = 1'b1;
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= COS_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        case (phase_reg)
            COS_IDLE: begin
                x_reg <= x_fold[COS_W-1:0];
            end
            COS_X2: begin
                x2_reg   <= prod_reg[59:29];
                t_reg    <= Q_ONE;
                step_reg <= '0;
            end
            COS_RECIP: begin
                n_reg <= prod_reg[59:29];
                if (step_reg == HORNER_STEPS) begin
                    cos_reg <= (q_last >= Q_ONE) ? '0 : (Q_ONE - q_last);
                end
            end
            COS_EST: begin
                q_reg <= prod_reg[61:32];
            end
            COS_FIX: begin
                t_reg    <= Q_ONE - q_fix;
                step_reg <= step_reg + 3'd1;
            end
            default: begin
                step_reg <= step_reg;
            end
        endcase
    end

endmodule

// ===== hdl/rpms_front.sv =====
// rpms_front: accepts input beats, classifies them and works out |cos(lat)| for queries
// depends on rpms_pkg and rpms_cos
module rpms_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic signed [31:0]       s_lon,
    input  logic signed [31:0]       s_lat,
    output logic                     push,
    output rpms_pkg::q_entry_t       push_entry,
    input  logic                     q_full
);
    import rpms_pkg::*;

    fr_state_t state_reg, state_next;
    q_entry_t  entry_reg;
    cos_req_t  cos_req;
    cos_rsp_t  cos_rsp;
    logic      accept;

    rpms_cos u_cos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cos_req),
        .rsp     (cos_rsp)
    );

    assign accept     = s_valid && s_ready;
    assign push_entry = entry_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: begin
                if (accept) begin
                    state_next = (s_mode == MODE_QUERY) ? FR_COS : FR_PUSH;
                end
            end
            FR_COS: begin
                if (cos_rsp.done) begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (!q_full) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == FR_IDLE);
        push          = (state_reg == FR_PUSH) && !q_full;
        cos_req.start = accept && (s_mode == MODE_QUERY);
        cos_req.lat   = s_lat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            entry_reg.op  <= classify(s_mode);
            entry_reg.lon <= s_lon;
            entry_reg.lat <= s_lat;
        end
        if (cos_rsp.done) begin
            entry_reg.cosv <= cos_rsp.cosv;
        end
    end

endmodule

// ===== hdl/rpms_queue.sv =====
// rpms_queue: short fifo of classified items between the front and the back
// depends on rpms_pkg
module rpms_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rpms_pkg::q_entry_t push_entry,
    output logic               q_full,
    input  logic               pop,
    output rpms_pkg::q_entry_t head,
    output logic               q_nonempty
);
    import rpms_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    q_entry_t        entries_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]   fill_reg, fill_next;

    assign q_full     = (fill_reg == FW'(QUEUE_DEPTH));
    assign q_nonempty = (fill_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr_reg + PW'(1));
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr_reg + PW'(1));
        end
        fill_next = fill_reg + FW'(push) - FW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/rpms_back.sv =====
// rpms_back: point table, radius register, scan sequencer, distance pipeline and result register
// depends on rpms_pkg
module rpms_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rpms_pkg::RADIUS_W-1:0] cfg_data,
    input  logic                          q_nonempty,
    input  rpms_pkg::q_entry_t            q_head,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic                          m_table_full,
    output logic [rpms_pkg::COUNT_OUT_W-1:0] m_stored_count
);
    import rpms_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    bk_state_t state_reg, state_next;

    logic [ANGLE_W-1:0] lon_mem [TABLE_DEPTH];
    logic [ANGLE_W-1:0] lat_mem [TABLE_DEPTH];

    logic [CW-1:0]       count_reg, count_next;
    logic [RADIUS_W-1:0] radius_reg;
    logic [61:0]         r2_reg;
    logic [AW-1:0]       idx_reg;
    logic [ANGLE_W-1:0]  qlon_reg, qlat_reg;
    logic [COS_W-1:0]    qcos_reg;
    logic                hit_acc_reg;

    logic [ANGLE_W-1:0]  rd_lon_reg, rd_lat_reg;
    logic [4:0]          v_reg;
    logic [32:0]         dphi2_reg, dlon2_reg;
    logic [32:0]         dphi3_reg;
    logic [62:0]         lam3_reg;
    logic                near4_reg;
    logic [61:0]         sqphi4_reg;
    logic [30:0]         dlam4_reg;
    logic                near5_reg;
    logic [61:0]         sqphi5_reg, sqlam5_reg;

    logic                      out_valid_reg;
    logic                      out_hit_reg, out_full_reg;
    logic [COUNT_OUT_W-1:0]    out_cnt_reg;

    logic        out_free, pipe_empty, last, issue, load, ld_hit, ld_full, wr_en, start_scan;
    logic [32:0] lat_diff, lon_diff, dphi_abs, dlon_abs;
    logic [33:0] dlam;
    logic        near;
    logic [62:0] dist_sq;

    assign cfg_ready      = 1'b1;
    assign m_valid        = out_valid_reg;
    assign m_hit          = out_hit_reg;
    assign m_table_full   = out_full_reg;
    assign m_stored_count = out_cnt_reg;

    assign out_free   = !out_valid_reg || m_ready;
    assign pipe_empty = (v_reg == '0);
    assign last       = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (start_scan) begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (last) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (pipe_empty) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        issue      = 1'b0;
        load       = 1'b0;
        ld_hit     = 1'b0;
        ld_full    = 1'b0;
        wr_en      = 1'b0;
        start_scan = 1'b0;
        count_next = count_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_nonempty && out_free) begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        OP_CLEAR: begin
                            count_next = '0;
                            load       = 1'b1;
                        end
                        OP_APPEND: begin
                            load = 1'b1;
                            if (count_reg < DEPTH_C) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end else begin
                                ld_full = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            if (count_reg == '0) begin
                                load = 1'b1;
                            end else begin
                                start_scan = 1'b1;
                            end
                        end
                        default: load = 1'b1;
                    endcase
                end
            end
            BK_SCAN: issue = 1'b1;
            BK_DRAIN: begin
                if (pipe_empty) begin
                    load   = 1'b1;
                    ld_hit = hit_acc_reg;
                end
            end
            default: issue = 1'b0;
        endcase
    end

    // distance datapath
    assign lat_diff = {rd_lat_reg[31], rd_lat_reg} - {qlat_reg[31], qlat_reg};
    assign lon_diff = {rd_lon_reg[31], rd_lon_reg} - {qlon_reg[31], qlon_reg};
    assign dphi_abs = lat_diff[32] ? (33'd0 - lat_diff) : lat_diff;
    assign dlon_abs = lon_diff[32] ? (33'd0 - lon_diff) : lon_diff;
    assign dlam     = lam3_reg[62:29];
    assign near     = (dphi3_reg < {2'd0, radius_reg}) && (dlam < {3'd0, radius_reg});
    assign dist_sq  = {1'b0, sqphi5_reg} + {1'b0, sqlam5_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            radius_reg    <= '0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            v_reg         <= {v_reg[3:0], issue};
            out_valid_reg <= load || (out_valid_reg && !m_ready);
            if (cfg_valid && cfg_ready) begin
                radius_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lon_mem[count_reg[AW-1:0]] <= q_head.lon;
            lat_mem[count_reg[AW-1:0]] <= q_head.lat;
        end
        rd_lon_reg <= lon_mem[idx_reg];
        rd_lat_reg <= lat_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        r2_reg <= 62'(radius_reg) * 62'(radius_reg);

        if (start_scan) begin
            idx_reg     <= '0;
            qlon_reg    <= q_head.lon;
            qlat_reg    <= q_head.lat;
            qcos_reg    <= q_head.cosv;
            hit_acc_reg <= 1'b0;
        end else begin
            if (issue) begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (v_reg[4] && near5_reg && (dist_sq < {1'b0, r2_reg})) begin
                hit_acc_reg <= 1'b1;
            end
        end

        dphi2_reg  <= dphi_abs;
        dlon2_reg  <= dlon_abs;
        dphi3_reg  <= dphi2_reg;
        lam3_reg   <= 63'(dlon2_reg) * 63'(qcos_reg);
        near4_reg  <= near;
        sqphi4_reg <= 62'(dphi3_reg[30:0]) * 62'(dphi3_reg[30:0]);
        dlam4_reg  <= dlam[30:0];
        near5_reg  <= near4_reg;
        sqphi5_reg <= sqphi4_reg;
        sqlam5_reg <= 62'(dlam4_reg) * 62'(dlam4_reg);

        if (load) begin
            out_hit_reg  <= ld_hit;
            out_full_reg <= ld_full;
            out_cnt_reg  <= COUNT_OUT_W'(count_next);
        end
    end

endmodule

// ===== hdl/radius_point_match_search.sv =====
// channel   | ports                                         | direction
// s_        | s_valid s_ready s_mode s_lon s_lat           | item in
// m_        | m_valid m_ready m_hit m_table_full m_stored_count | result out
// cfg_      | cfg_valid cfg_ready cfg_data                  | radius write
//
// clear, append and idle codes give a result without a scan; the front takes a new beat
// only once it has pushed the last one to the queue; a query passes the front cosine unit
// (one shared 32x32 multiplier; multiply, reciprocal, estimate and fix steps per term), then
// the back scan: one table entry per cycle through the memory read port and distance pipeline
// reset clears the count and the radius; table contents stay undefined until appended
// the queue lets the front take the next beat while a scan runs or the result waits
//
// radius_point_match_search: top level, front, queue and back joined
// depends on rpms_pkg, rpms_front, rpms_queue and rpms_back
module radius_point_match_search #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_mode,
    input  logic signed [31:0]                s_lon,
    input  logic signed [31:0]                s_lat,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic                              m_table_full,
    output logic [rpms_pkg::COUNT_OUT_W-1:0]  m_stored_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpms_pkg::RADIUS_W-1:0]     cfg_data
);
    import rpms_pkg::*;

    logic     push, q_full, q_pop, q_nonempty;
    q_entry_t push_entry, q_head;

    rpms_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_lon      (s_lon),
        .s_lat      (s_lat),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    rpms_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .q_nonempty (q_nonempty)
    );

    rpms_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .q_nonempty     (q_nonempty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_table_full   (m_table_full),
        .m_stored_count (m_stored_count)
    );

endmodule

// ===== hdl/rpms_check.sv =====
// rpms_check: port level checks on the result channel, bound to the top level
// depends on radius_point_match_search ports only
module rpms_check #(
    parameter int TABLE_DEPTH = 256
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_hit,
    input logic       m_table_full,
    input logic [8:0] m_stored_count
);

    a_valid_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat withdrawn before it was taken");

    a_payload_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_hit) && $stable(m_table_full)
                                && $stable(m_stored_count))
        else $error("result beat changed while stalled");

    a_hit_or_full : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_table_full))
        else $error("hit and table full reported on one beat");

    a_full_count : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> m_stored_count == 9'(TABLE_DEPTH))
        else $error("dropped append with table not at capacity");

    a_empty_no_hit : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (TABLE_DEPTH < 512) && m_stored_count == 9'd0 |-> !m_hit)
        else $error("hit reported on an empty table");

endmodule

bind radius_point_match_search rpms_check #(.TABLE_DEPTH(TABLE_DEPTH)) u_rpms_check (.*);
